/* design/q4ecm_pkg.sv */
// Package for the quad4 element conductivity matrix core.
// Holds the fixed datapath widths and the request and result payload types.
// No dependencies.
package q4ecm_pkg;

  localparam int unsigned CondW      = 31;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned ACC_WIDTH  = 48;

  typedef struct packed {
    logic        action;
    logic [1:0]  node_slot;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
    logic [30:0] weight_product;
    logic        last_point;
  } q4ecm_in_t;

  typedef struct packed {
    logic [1:0]  row;
    logic [1:0]  col;
    logic signed [47:0] h_value;
    logic        singular;
    logic        last;
  } q4ecm_out_t;

endpackage

/* design/quad4_element_conductivity_matrix_core.sv */
// Quad4 element conductivity matrix core: one module with a small sequencer
// around a single shared saturating multiply-add unit. Depends on q4ecm_pkg.
//
// Usage: a coordinate or derivative request for nodes 0..2 is only stored.
// A derivative request for node 3 runs the point: the Jacobian and
// determinant, the reciprocal (one quotient bit a cycle, then a finishing
// step), the inverse and dN/dx, dN/dy, and the 16 accumulator entries.
// The divider aside, all products go through one 33x33 multiplier, which
// sets the rate; products of a 48-bit partial term take two passes through
// it. On the last point the 16 entries then leave one per accepted result,
// and the accumulator and singular flag clear as they go. A zero determinant
// ends the point right after the determinant. in_stall_o is high while a
// point or the emission runs.
module quad4_element_conductivity_matrix_core
  import q4ecm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  q4ecm_in_t  in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output q4ecm_out_t out_data_o,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [CondW-1:0] cfg_data
);

  localparam int unsigned PW = 2 * ACC_WIDTH + 2;
  localparam int unsigned MW = 2 * DATA_WIDTH + 2;
  localparam int unsigned HalfW = ACC_WIDTH / 2;
  localparam int unsigned DivW = 2 * FRAC_BITS + 1;
  localparam int unsigned DivCntW = $clog2(DivW + 1);
  localparam logic signed [ACC_WIDTH-1:0] DMax = ACC_WIDTH'((65'sd1 <<< (DATA_WIDTH-1)) - 1);
  localparam logic signed [ACC_WIDTH-1:0] DMin = -DMax - ACC_WIDTH'(1);
  localparam logic signed [ACC_WIDTH-1:0] AMax = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] AMin = {1'b1, {(ACC_WIDTH-1){1'b0}}};
  localparam logic signed [ACC_WIDTH-1:0] OMax = ACC_WIDTH'((65'sd1 <<< 47) - 1);
  localparam logic signed [ACC_WIDTH-1:0] OMin = -OMax - ACC_WIDTH'(1);

  typedef enum logic [3:0] {
    S_IDLE, S_JAC, S_DET, S_DIV, S_INV, S_DXY, S_TERM, S_EMIT
  } state_e;

  typedef logic signed [ACC_WIDTH-1:0] aw_t;

  // operand storage, kept at ACC_WIDTH for one shared datapath
  aw_t nx_q [4], ny_q [4], dk_q [4], de_q [4], dx_q [4], dy_q [4];
  aw_t acc_q [16];
  aw_t jm_q [4];
  aw_t inv_q [4];
  aw_t w_q, det_q, rinv_q, t_q, sum_q;
  logic [CondW-1:0] cond_q;
  logic sing_q, last_q;
  state_e state_q;
  logic [3:0] cnt_q;
  logic [2:0] sub_q;
  logic [DivCntW-1:0] dcnt_q;
  logic [DivW:0] rem_q;
  logic [DivW-1:0] quo_q, dvs_q;
  logic ph_q;
  logic signed [MW-1:0] pp_q;

  // shared unit: (a*b)>>FRAC, saturate to lim, optional add to c
  aw_t mu_a, mu_b, mu_c, mu_hi, mu_lo, mu_r, mu_p;
  logic mu_add;
  logic signed [PW-1:0] prod, prod_s;
  logic signed [ACC_WIDTH:0] sum_w;
  logic signed [DATA_WIDTH:0] mm_a, mm_b;
  logic signed [MW-1:0] mm_p;
  logic mu_wide, mu_step;

  // a 48-bit partial term is multiplied in two passes, upper half first
  assign mu_wide = (state_q == S_TERM) && (sub_q >= 3'd2);
  assign mu_step = !mu_wide || ph_q;

  always_comb begin
    mm_b = mu_b[DATA_WIDTH:0];
    if (mu_wide && !ph_q) mm_a = (DATA_WIDTH+1)'($signed(mu_a[ACC_WIDTH-1:HalfW]));
    else if (mu_wide) mm_a = (DATA_WIDTH+1)'({1'b0, mu_a[HalfW-1:0]});
    else mm_a = mu_a[DATA_WIDTH:0];
    mm_p = mm_a * mm_b;
    if (mu_wide) prod = (PW'(pp_q) <<< HalfW) + PW'(mm_p);
    else prod = PW'(mm_p);
    prod_s = prod >>> FRAC_BITS;
    // truncate toward zero
    if (prod < 0 && prod[FRAC_BITS-1:0] != '0) prod_s = prod_s + PW'(1);
    if (prod_s > PW'(mu_hi)) mu_p = mu_hi;
    else if (prod_s < PW'(mu_lo)) mu_p = mu_lo;
    else mu_p = ACC_WIDTH'(prod_s);
    sum_w = (mu_add ? (ACC_WIDTH+1)'(mu_c) : '0) + (ACC_WIDTH+1)'(mu_p);
    if (sum_w > (ACC_WIDTH+1)'(mu_hi)) mu_r = mu_hi;
    else if (sum_w < (ACC_WIDTH+1)'(mu_lo)) mu_r = mu_lo;
    else mu_r = ACC_WIDTH'(sum_w);
  end

  logic [1:0] ci, cj;
  assign ci = cnt_q[3:2];
  assign cj = cnt_q[1:0];

  // operand select for the shared unit
  always_comb begin
    mu_a = '0; mu_b = '0; mu_c = sum_q; mu_add = 1'b1; mu_hi = DMax; mu_lo = DMin;
    unique case (state_q)
      S_JAC: begin
        mu_a = cnt_q[1] ? de_q[sub_q[1:0]] : dk_q[sub_q[1:0]];
        mu_b = cnt_q[0] ? ny_q[sub_q[1:0]] : nx_q[sub_q[1:0]];
        mu_add = (sub_q != 3'd0);
      end
      // j01*j10 first, then j00*j11 minus it
      S_DET: begin
        mu_a = cnt_q[0] ? jm_q[0] : jm_q[1];
        mu_b = cnt_q[0] ? jm_q[3] : jm_q[2];
        mu_c = -sum_q;
        mu_add = cnt_q[0];
      end
      S_INV: begin
        unique case (cnt_q[1:0])
          2'd0: mu_a = jm_q[3];
          2'd1: mu_a = -jm_q[1];
          2'd2: mu_a = -jm_q[2];
          default: mu_a = jm_q[0];
        endcase
        mu_b = rinv_q; mu_add = 1'b0;
      end
      S_DXY: begin
        mu_a = sub_q[0] ? de_q[cnt_q[1:0]] : dk_q[cnt_q[1:0]];
        mu_b = inv_q[{cnt_q[2], sub_q[0]}];
        mu_add = sub_q[0];
      end
      S_TERM: begin
        mu_hi = AMax; mu_lo = AMin;
        unique case (sub_q)
          3'd0: begin mu_a = dx_q[ci]; mu_b = dx_q[cj]; mu_add = 1'b0; end
          3'd1: begin mu_a = dy_q[ci]; mu_b = dy_q[cj]; end
          3'd2: begin mu_a = t_q; mu_b = aw_t'(cond_q); mu_add = 1'b0; end
          3'd3: begin mu_a = t_q; mu_b = det_q; mu_add = 1'b0; end
          default: begin mu_a = t_q; mu_b = w_q; mu_c = acc_q[cnt_q[3:0]]; end
        endcase
      end
      default: mu_add = 1'b0;
    endcase
  end

  logic in_acc, out_acc, pt_go;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_o && !out_stall_i;
  assign cfg_ready   = (state_q == S_IDLE);
  assign pt_go       = in_acc && in_data_i.action && (in_data_i.node_slot == 2'd3);
  assign out_valid_o = (state_q == S_EMIT);

  aw_t acc_e, va_s, vb_s;
  always_comb begin
    acc_e = acc_q[cnt_q[3:0]];
    if (acc_e > OMax) acc_e = OMax;
    else if (acc_e < OMin) acc_e = OMin;
    out_data_o.row      = ci;
    out_data_o.col      = cj;
    out_data_o.h_value  = 48'(acc_e);
    out_data_o.singular = sing_q;
    out_data_o.last     = (cnt_q[3:0] == 4'd15);
    va_s = aw_t'(in_data_i.value_a);
    vb_s = aw_t'(in_data_i.value_b);
    if (va_s > DMax) va_s = DMax; else if (va_s < DMin) va_s = DMin;
    if (vb_s > DMax) vb_s = DMax; else if (vb_s < DMin) vb_s = DMin;
  end

  logic [DivW:0] rem_t;
  assign rem_t = {rem_q[DivW-1:0], 1'b0};

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cond_q <= CondW'(65536);
    end else if (cfg_valid && cfg_ready) begin
      cond_q <= cfg_data;
    end
  end

  // payload stores
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (!in_data_i.action) begin
        nx_q[in_data_i.node_slot] <= va_s;
        ny_q[in_data_i.node_slot] <= vb_s;
      end else begin
        dk_q[in_data_i.node_slot] <= va_s;
        de_q[in_data_i.node_slot] <= vb_s;
        w_q <= aw_t'(in_data_i.weight_product);
      end
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= '0; sub_q <= '0; sing_q <= 1'b0; last_q <= 1'b0;
      dcnt_q <= '0; ph_q <= 1'b0;
      for (int n = 0; n < 16; n++) acc_q[n] <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: if (pt_go) begin
          last_q <= in_data_i.last_point;
          state_q <= S_JAC; cnt_q <= '0; sub_q <= '0;
        end
        // four 4-term dot products
        S_JAC: begin
          sum_q <= mu_r;
          sub_q <= sub_q + 3'd1;
          if (sub_q == 3'd3) begin
            jm_q[cnt_q[1:0]] <= mu_r; sub_q <= '0; cnt_q <= cnt_q + 4'd1;
            if (cnt_q[1:0] == 2'd3) begin state_q <= S_DET; cnt_q <= '0; end
          end
        end
        S_DET: begin
          sum_q <= mu_r;
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q[0]) begin
            det_q <= mu_r; cnt_q <= '0;
            if (mu_r == '0) begin
              sing_q <= 1'b1;
              state_q <= last_q ? S_EMIT : S_IDLE;
            end else begin
              state_q <= S_DIV; dcnt_q <= '0;
              rem_q <= '0; quo_q <= '0;
              dvs_q <= DivW'(mu_r < 0 ? -mu_r : mu_r);
            end
          end
        end
        // restoring divide of 2^(2F) by |det|, one bit a cycle
        S_DIV: begin
          if (dcnt_q == DivCntW'(DivW)) begin
            state_q <= S_INV; cnt_q <= '0;
            if (det_q < 0) rinv_q <= (aw_t'(quo_q) > -DMin) ? DMin : -aw_t'(quo_q);
            else rinv_q <= (aw_t'(quo_q) > DMax) ? DMax : aw_t'(quo_q);
          end else begin
            dcnt_q <= dcnt_q + DivCntW'(1);
            if (rem_t + (DivW+1)'(dcnt_q == '0) >= {1'b0, dvs_q}) begin
              rem_q <= rem_t + (DivW+1)'(dcnt_q == '0) - {1'b0, dvs_q};
              quo_q <= {quo_q[DivW-2:0], 1'b1};
            end else begin
              rem_q <= rem_t + (DivW+1)'(dcnt_q == '0);
              quo_q <= {quo_q[DivW-2:0], 1'b0};
            end
          end
        end
        S_INV: begin
          inv_q[cnt_q[1:0]] <= mu_r;
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q[1:0] == 2'd3) begin state_q <= S_DXY; cnt_q <= '0; sub_q <= '0; end
        end
        // cnt[2] picks dy, cnt[1:0] the node
        S_DXY: begin
          sum_q <= mu_r;
          sub_q <= {2'b0, ~sub_q[0]};
          if (sub_q[0]) begin
            if (cnt_q[2]) dy_q[cnt_q[1:0]] <= mu_r; else dx_q[cnt_q[1:0]] <= mu_r;
            cnt_q <= cnt_q + 4'd1;
            if (cnt_q[2:0] == 3'd7) begin state_q <= S_TERM; cnt_q <= '0; end
          end
        end
        // hold the upper partial product, then finish the step
        S_TERM: begin
          if (!mu_step) begin
            ph_q <= 1'b1; pp_q <= mm_p;
          end else begin
            ph_q <= 1'b0;
            sum_q <= mu_r; t_q <= mu_r;
            sub_q <= sub_q + 3'd1;
            if (sub_q == 3'd4) begin
              acc_q[cnt_q[3:0]] <= mu_r; sub_q <= '0; cnt_q <= cnt_q + 4'd1;
              if (cnt_q[3:0] == 4'd15) begin
                cnt_q <= '0; state_q <= last_q ? S_EMIT : S_IDLE;
              end
            end
          end
        end
        S_EMIT: if (out_acc) begin
          acc_q[cnt_q[3:0]] <= '0;
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q[3:0] == 4'd15) begin
            cnt_q <= '0; sing_q <= 1'b0; state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_out_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !out_valid_o) else $error("result while idle");
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("request taken during emit");
  a_emit_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_data_o.last) |=> (state_q == S_IDLE && !sing_q))
    else $error("emit did not close");
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready |-> !out_valid_o) else $error("config open while busy");
`endif

endmodule
